FILE: rtl/core/psrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psrs_pkg;

	// Store geometry.
	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;

	// Coordinate and distance arithmetic.
	localparam int COORD_W  = 16;
	localparam int ABS_W    = COORD_W + 1;
	localparam int SQ_W     = 2 * ABS_W;
	localparam int DIST_W   = SQ_W + 2;
	localparam int RAD_W    = 15;
	localparam int R2_W     = 2 * RAD_W;
	localparam int ACT_W    = 3;
	localparam int PT_W     = 3 * COORD_W;
	localparam logic [ABS_W-1:0] DIFF_CAP = ABS_W'(65536);

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND  = 3'd0,
		ACT_CLEAR   = 3'd1,
		ACT_NEAREST = 3'd2,
		ACT_COUNT   = 3'd3,
		ACT_REMOVE  = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic issue;
		logic commit;
		logic out_load;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic is_search;
		logic scan_more;
		logic pipe_empty;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/point_set_radius_search_core.sv
// Append, clear and unused action codes are captured, executed and then loaded into the
// output register. Nearest, count and remove are captured and then scan the N points held,
// drain the pipe and commit before the load; the scan is paced by the single read port of
// the point store, which the scan walks one point per cycle through a four-stage pipe. One
// item is worked at a time; a finished result waits in the output register while the next
// is taken. Reset (arst_n low) empties the store and clears all handshake state; point data
// is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module point_set_radius_search_core import psrs_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [ACT_W-1:0]          action,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic signed [COORD_W-1:0] point_z,
	input  wire logic [RAD_W-1:0]          radius,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           found,
	output logic [IDX_W-1:0]               nearest_index,
	output logic [CNT_W-1:0]               match_count,
	output logic [CNT_W-1:0]               points_held,
	output logic                           status
);

	// The controller sequences each beat: capture, then either an execute state
	// (append, clear or an unused code) or a scan over all stored points followed by a
	// pipeline drain and commit, and finally a load into the output register.
	cmd_t cmd;
	sts_t sts;

	psrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath holds the point store, the distance pipeline (read, absolute
	// difference, square, sum) and the running best, count and compaction index.
	// Removal compacts in place: surviving points are written back at an index
	// that never passes the one being read.
	psrs_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.radius        (radius),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.found         (found),
		.nearest_index (nearest_index),
		.match_count   (match_count),
		.points_held   (points_held),
		.status        (status)
	);

endmodule

`default_nettype wire

FILE: rtl/core/psrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module psrs_ctrl import psrs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output cmd_t      cmd,
	input  sts_t      sts
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = sts.is_search ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (!sts.scan_more) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = !sts.is_search;
			end
			ST_SCAN: begin
				cmd.issue = sts.scan_more;
			end
			ST_DRAIN: begin
				cmd.commit = sts.pipe_empty;
			end
			ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/psrs_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module psrs_dpath import psrs_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  cmd_t                           cmd,
	output sts_t                           sts,
	input  wire logic [ACT_W-1:0]          action,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic signed [COORD_W-1:0] point_z,
	input  wire logic [RAD_W-1:0]          radius,
	input  wire logic                      out_stall,
	output logic                           out_valid,
	output logic                           found,
	output logic [IDX_W-1:0]               nearest_index,
	output logic [CNT_W-1:0]               match_count,
	output logic [CNT_W-1:0]               points_held,
	output logic                           status
);

	// Absolute coordinate difference, saturated at the difference cap.
	function automatic logic [ABS_W-1:0] abs_diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [ABS_W-1:0] d;
		logic [ABS_W-1:0] m;
		d = ABS_W'(a) - ABS_W'(b);
		m = d[ABS_W-1] ? ABS_W'(-d) : ABS_W'(d);
		if (m > DIFF_CAP) m = DIFF_CAP;
		return m;
	endfunction

	logic [PT_W-1:0] store_q [MAX_POINTS];

	// Item registers.
	act_t             action_q;
	point_t           centre_q;
	logic [R2_W-1:0]  r2_q;

	// Store control.
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] wr_idx_q;

	// Scan pipeline.
	logic             v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	point_t           pt_s1, pt_s2, pt_s3, pt_s4;
	logic [ABS_W-1:0] dx_s2, dy_s2, dz_s2;
	logic [SQ_W-1:0]  sx_s3, sy_s3, sz_s3;
	logic [DIST_W-1:0] dist_s4;

	// Accumulated result.
	logic              found_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              status_q;
	logic [DIST_W-1:0] best_q;
	logic              out_valid_q;

	logic              full;
	logic              in_range;
	logic              closer;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [PT_W-1:0]   wr_data;

	assign full     = (total_q == CNT_W'(MAX_POINTS));
	assign in_range = (dist_s4 < DIST_W'(r2_q));
	assign closer   = (dist_s4 < best_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_idx_q[IDX_W-1:0];
		wr_data = pt_s4;
		if (cmd.exec && action_q == ACT_APPEND && !full) begin
			wr_en   = 1'b1;
			wr_addr = total_q[IDX_W-1:0];
			wr_data = centre_q;
		end else if (v_s4 && action_q == ACT_REMOVE && !in_range) begin
			wr_en = 1'b1;
		end
	end

	assign sts.is_search  = (action_q == ACT_NEAREST) || (action_q == ACT_COUNT)
		|| (action_q == ACT_REMOVE);
	assign sts.scan_more  = (rd_idx_q < total_q);
	assign sts.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign sts.out_free   = !out_valid_q || !out_stall;

	// Point store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) store_q[wr_addr] <= wr_data;
		if (cmd.issue) pt_s1 <= store_q[rd_idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cmd.load) begin
				rd_idx_q <= '0;
				wr_idx_q <= '0;
			end else begin
				if (cmd.issue) rd_idx_q <= rd_idx_q + 1'b1;
				if (v_s4 && action_q == ACT_REMOVE && !in_range) wr_idx_q <= wr_idx_q + 1'b1;
			end
			if (cmd.exec && action_q == ACT_APPEND && !full) begin
				total_q <= total_q + 1'b1;
			end else if (cmd.exec && action_q == ACT_CLEAR) begin
				total_q <= '0;
			end else if (cmd.commit && action_q == ACT_REMOVE) begin
				total_q <= wr_idx_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q   <= act_t'(action);
			centre_q.x <= point_x;
			centre_q.y <= point_y;
			centre_q.z <= point_z;
			r2_q       <= R2_W'(radius) * R2_W'(radius);
			found_q    <= 1'b0;
			idx_q      <= '0;
			cnt_q      <= '0;
			status_q   <= 1'b0;
			best_q     <= DIST_W'(R2_W'(radius) * R2_W'(radius));
		end else begin
			if (cmd.exec && action_q == ACT_APPEND && full) status_q <= 1'b1;
			if (v_s4) begin
				if ((action_q == ACT_COUNT || action_q == ACT_REMOVE) && in_range) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (action_q == ACT_NEAREST && closer) begin
					best_q  <= dist_s4;
					idx_q   <= idx_s4;
					found_q <= 1'b1;
				end
			end
		end

		idx_s1  <= rd_idx_q[IDX_W-1:0];
		idx_s2  <= idx_s1;
		idx_s3  <= idx_s2;
		idx_s4  <= idx_s3;
		pt_s2   <= pt_s1;
		pt_s3   <= pt_s2;
		pt_s4   <= pt_s3;
		dx_s2   <= abs_diff(pt_s1.x, centre_q.x);
		dy_s2   <= abs_diff(pt_s1.y, centre_q.y);
		dz_s2   <= abs_diff(pt_s1.z, centre_q.z);
		sx_s3   <= dx_s2 * dx_s2;
		sy_s3   <= dy_s2 * dy_s2;
		sz_s3   <= dz_s2 * dz_s2;
		dist_s4 <= DIST_W'(sx_s3) + DIST_W'(sy_s3) + DIST_W'(sz_s3);

		if (cmd.out_load) begin
			found         <= found_q;
			nearest_index <= idx_q;
			match_count   <= cnt_q;
			points_held   <= total_q;
			status        <= status_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_POINTS))
		else $error("point count exceeds the store capacity");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		wr_idx_q <= rd_idx_q)
		else $error("compaction write index overtook the read index");

	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (rd_idx_q < total_q))
		else $error("scan read beyond the stored points");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a beat not yet taken");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import psrs_pkg::*;

	// Action codes that the package leaves unnamed. The block must ignore them,
	// apart from reporting how many points it holds.
	localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;
	localparam logic [RAD_W-1:0] RADIUS_MAX  = '1;

	// One result beat as the block should present it.
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] held;
		logic             status;
	} search_outcome_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [ACT_W-1:0]          action = '0;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic signed [COORD_W-1:0] point_z = '0;
	logic [RAD_W-1:0]          radius = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      found;
	logic [IDX_W-1:0]          nearest_index;
	logic [CNT_W-1:0]          match_count;
	logic [CNT_W-1:0]          points_held;
	logic                      status;

	// Our own copy of the point store and its fill level, updated as each beat
	// is accepted on the input side.
	point_t          shadow_points [MAX_POINTS];
	int              shadow_total = 0;
	search_outcome_t pending_outcomes [$];
	int              error_count = 0;
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;

	point_set_radius_search_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.radius        (radius),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.found         (found),
		.nearest_index (nearest_index),
		.match_count   (match_count),
		.points_held   (points_held),
		.status        (status)
	);

	always #1 clk = ~clk;

	// The receiver stalls at random; the rate is changed between phases of the run.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Squared difference along one axis. The difference is exact, and its
	// magnitude is capped before squaring, as the block's datapath does.
	function automatic longint unsigned axis_square(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		longint gap;
		gap = longint'(a) - longint'(b);
		if (gap < 0)
			gap = -gap;
		if (gap > longint'(DIFF_CAP))
			gap = longint'(DIFF_CAP);
		return gap * gap;
	endfunction

	function automatic longint unsigned squared_distance(input point_t p, input point_t c);
		return axis_square(p.x, c.x) + axis_square(p.y, c.y) + axis_square(p.z, c.z);
	endfunction

	// Works out the result of one action and applies it to the shadow store.
	// A point counts as inside only when its squared distance is strictly
	// below the squared radius, so a zero radius never matches anything.
	function automatic search_outcome_t predict_outcome(input logic [ACT_W-1:0] act,
			input point_t centre, input logic [RAD_W-1:0] rad);
		search_outcome_t  o;
		longint unsigned  r_sq;
		longint unsigned  best;
		longint unsigned  d;
		int               kept;
		o = '0;
		r_sq = longint'(rad) * longint'(rad);
		best = r_sq;
		kept = 0;
		case (act)
			ACT_APPEND: begin
				if (shadow_total >= MAX_POINTS) begin
					o.status = 1'b1;
				end else begin
					shadow_points[shadow_total] = centre;
					shadow_total++;
				end
			end
			ACT_CLEAR: begin
				shadow_total = 0;
			end
			ACT_NEAREST: begin
				// Only a strictly smaller distance replaces the best, so ties keep
				// the earliest stored point.
				for (int k = 0; k < shadow_total; k++) begin
					d = squared_distance(shadow_points[k], centre);
					if (d < best) begin
						best = d;
						o.found = 1'b1;
						o.idx = IDX_W'(k);
					end
				end
			end
			ACT_COUNT: begin
				for (int k = 0; k < shadow_total; k++)
					if (squared_distance(shadow_points[k], centre) < r_sq)
						o.cnt++;
			end
			ACT_REMOVE: begin
				// Survivors slide down in their original order.
				for (int k = 0; k < shadow_total; k++) begin
					if (squared_distance(shadow_points[k], centre) >= r_sq) begin
						shadow_points[kept] = shadow_points[k];
						kept++;
					end
				end
				o.cnt = CNT_W'(shadow_total - kept);
				shadow_total = kept;
			end
			default: ;
		endcase
		o.held = CNT_W'(shadow_total);
		return o;
	endfunction

	// Offers one beat, idling beforehand at the current sender rate, and holds
	// it steady until the block takes it. The valid line is left high after
	// acceptance; the next call or the end of the run decides whether it drops.
	task automatic send_beat(input logic [ACT_W-1:0] act, input point_t p,
			input logic [RAD_W-1:0] rad);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		point_x  <= p.x;
		point_y  <= p.y;
		point_z  <= p.z;
		radius   <= rad;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_outcomes.push_back(predict_outcome(act, p, rad));
	endtask

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	// Every result beat taken from the block is matched against the oldest
	// prediction still waiting.
	always @(posedge clk) begin : result_check
		search_outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				$error("result beat arrived with no prediction waiting");
				error_count++;
			end else begin
				want = pending_outcomes.pop_front();
				compare_field("found", 16'(want.found), 16'(found));
				compare_field("nearest_index", 16'(want.idx), 16'(nearest_index));
				compare_field("match_count", 16'(want.cnt), 16'(match_count));
				compare_field("points_held", 16'(want.held), 16'(points_held));
				compare_field("status", 16'(want.status), 16'(status));
			end
		end
	end

	function automatic point_t make_point(input int x, input int y, input int z);
		point_t p;
		p.x = COORD_W'(x);
		p.y = COORD_W'(y);
		p.z = COORD_W'(z);
		return p;
	endfunction

	function automatic point_t random_point();
		return point_t'(PT_W'({$urandom, $urandom}));
	endfunction

	// A point scattered around a centre by up to the given spread on each axis.
	// Coordinates wrap at the edges of the signed range.
	function automatic point_t jitter(input point_t c, input int spread);
		return make_point(int'(c.x) + int'($urandom_range(0, 2 * spread)) - spread,
			int'(c.y) + int'($urandom_range(0, 2 * spread)) - spread,
			int'(c.z) + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	// Mostly radii of the same order as the cluster spread, so that searches
	// both hit and miss; now and then any radius at all.
	function automatic logic [RAD_W-1:0] pick_radius();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return RAD_W'($urandom_range(0, 600));
		else if (roll < 85)
			return RAD_W'($urandom_range(0, 4000));
		return RAD_W'($urandom);
	endfunction

	// Searches on an empty store must find nothing, whatever the radius.
	task automatic test_empty_store;
		send_beat(ACT_NEAREST, make_point(0, 0, 0), RADIUS_MAX);
		send_beat(ACT_COUNT, make_point(-1, -1, -1), RADIUS_MAX);
		send_beat(ACT_REMOVE, make_point(0, 0, 0), RADIUS_MAX);
	endtask

	// Opposite corners of the coordinate range give the largest per-axis
	// difference the block can see.
	task automatic test_extreme_coords;
		point_t lo_corner;
		point_t hi_corner;
		lo_corner = make_point(-32768, -32768, -32768);
		hi_corner = make_point(32767, 32767, 32767);
		send_beat(ACT_APPEND, lo_corner, '0);
		send_beat(ACT_APPEND, hi_corner, RADIUS_MAX);
		send_beat(ACT_NEAREST, hi_corner, RADIUS_MAX);
		send_beat(ACT_NEAREST, lo_corner, RADIUS_MAX);
		send_beat(ACT_COUNT, make_point(-32768, 32767, 0), RADIUS_MAX);
	endtask

	// A point exactly on the radius is outside; one unit more brings it in.
	// A zero radius matches nothing, not even a point at the centre.
	task automatic test_radius_edges;
		send_beat(ACT_APPEND, make_point(10, 0, 0), '0);
		send_beat(ACT_COUNT, make_point(0, 0, 0), RAD_W'(10));
		send_beat(ACT_COUNT, make_point(0, 0, 0), RAD_W'(11));
		send_beat(ACT_NEAREST, make_point(10, 0, 0), '0);
		send_beat(ACT_COUNT, make_point(10, 0, 0), '0);
		send_beat(ACT_REMOVE, make_point(10, 0, 0), '0);
	endtask

	// Equal distances go to the earlier point, and a remove keeps the order
	// of the points that survive it.
	task automatic test_ties_and_order;
		send_beat(ACT_APPEND, make_point(100, 100, 100), '0);
		send_beat(ACT_APPEND, make_point(100, 100, 100), '0);
		send_beat(ACT_NEAREST, make_point(100, 100, 101), RAD_W'(2));
		send_beat(ACT_REMOVE, make_point(10, 0, 0), RAD_W'(1));
		send_beat(ACT_NEAREST, make_point(100, 100, 100), RAD_W'(1));
		send_beat(ACT_NEAREST, make_point(32767, 32767, 32767), RADIUS_MAX);
	endtask

	task automatic test_unused_actions;
		send_beat(ACT_SPARE_A, random_point(), RAD_W'($urandom));
		send_beat(ACT_SPARE_B, random_point(), RAD_W'($urandom));
		send_beat(ACT_SPARE_C, random_point(), RAD_W'($urandom));
		send_beat(ACT_CLEAR, random_point(), RAD_W'($urandom));
	endtask

	// Fills the store to capacity with points near the origin, so that the
	// widest radius takes in every one of them, then overfills it.
	task automatic test_full_store;
		point_t last_pt;
		last_pt = '0;
		send_beat(ACT_CLEAR, '0, '0);
		for (int k = 0; k < MAX_POINTS; k++) begin
			last_pt = jitter('0, 2000);
			send_beat(ACT_APPEND, last_pt, '0);
		end
		for (int k = 0; k < 3; k++)
			send_beat(ACT_APPEND, random_point(), RAD_W'($urandom));
		// The last point sits at the top index unless an earlier one repeats it.
		send_beat(ACT_NEAREST, last_pt, RAD_W'(1));
		send_beat(ACT_COUNT, '0, RADIUS_MAX);
		send_beat(ACT_NEAREST, '0, RADIUS_MAX);
		send_beat(ACT_REMOVE, '0, RAD_W'(1000));
		send_beat(ACT_COUNT, '0, RADIUS_MAX);
		send_beat(ACT_REMOVE, '0, RADIUS_MAX);
		send_beat(ACT_APPEND, last_pt, '0);
		send_beat(ACT_CLEAR, '0, '0);
	endtask

	// Random traffic built around a moving cluster centre: appends land near
	// it and queries probe it, so searches see mixes of near and far points.
	// The store is cleared or thinned once it grows past a few dozen points,
	// which keeps scans short. A small share is pure noise, spare codes included.
	task automatic run_random_mix(input int n_items);
		point_t           hub;
		point_t           p;
		logic [ACT_W-1:0] act;
		logic [RAD_W-1:0] rad;
		int               roll;
		int               spread;
		hub = random_point();
		for (int k = 0; k < n_items; k++) begin
			if (k % 40 == 0)
				hub = random_point();
			roll = $urandom_range(0, 99);
			spread = ($urandom_range(0, 3) == 0) ? 3 : ($urandom_range(0, 1) ? 200 : 2000);
			p = jitter(hub, 300);
			rad = pick_radius();
			if (shadow_total >= 64) begin
				act = (roll < 40) ? ACT_CLEAR : ACT_REMOVE;
				rad = RAD_W'($urandom_range(500, 32767));
			end else if (roll < 42) begin
				act = ACT_APPEND;
				p = ($urandom_range(0, 9) == 0) ? random_point() : jitter(hub, spread);
			end else if (roll < 60) begin
				act = ACT_NEAREST;
			end else if (roll < 75) begin
				act = ACT_COUNT;
			end else if (roll < 86) begin
				act = ACT_REMOVE;
			end else if (roll < 89) begin
				act = ACT_CLEAR;
			end else if (roll < 93) begin
				act = ($urandom_range(0, 1)) ? ACT_SPARE_A : (roll[0] ? ACT_SPARE_B : ACT_SPARE_C);
			end else begin
				act = ACT_W'($urandom);
				p = random_point();
				rad = RAD_W'($urandom);
			end
			send_beat(act, p, rad);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sender mostly busy, receiver often stalling.
		send_idle_pct = 36;
		recv_idle_pct = 73;
		test_empty_store();
		test_extreme_coords();
		test_radius_edges();
		test_ties_and_order();
		test_unused_actions();
		run_random_mix(200);

		// The other way round: sparse input, eager receiver.
		send_idle_pct = 73;
		recv_idle_pct = 36;
		run_random_mix(190);

		// Back-to-back beats on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_full_store();
		run_random_mix(190);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		// Any stray beat after the last expected one would show up here.
		repeat (MAX_POINTS + 8) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// This is a hang guard that ends the run as a failure.
	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/psrs_pkg.sv
rtl/core/psrs_ctrl.sv
rtl/core/psrs_dpath.sv
rtl/core/point_set_radius_search_core.sv
tb/testbench.sv
